/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge out of reset
`define WSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent now implies consequent on the next edge
`define WSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/wsd_pkg.sv */
// ----------------------------------------------------------------------------
// wsd_pkg
// types and constants of the section deframer
// ----------------------------------------------------------------------------
package wsd_pkg;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_RECORD  = 2'd1,
    KIND_OK      = 2'd2,
    KIND_FAIL    = 2'd3
  } kind_e;

  // one result as it waits in the output queue
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  section_id;
    logic [31:0] section_size;
    logic [7:0]  payload_byte;
    logic        last_of_run;
  } res_t;

  // results written for one accepted request
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  localparam int unsigned RQ_DEPTH = 4;

  localparam logic [2:0] HDR_LAST       = 3'd7;
  localparam logic [2:0] SIZE_MAX_BYTES = 3'd5;
  localparam logic [7:0] MAGIC_A        = 8'h61;
  localparam logic [7:0] MAGIC_S        = 8'h73;
  localparam logic [7:0] MAGIC_M        = 8'h6D;
  localparam logic [7:0] VERSION_1      = 8'h01;
  localparam logic [7:0] LEB_DATA_MASK  = 8'h7F;
  localparam logic [7:0] LEB_CONT_MASK  = 8'h80;

  // expected byte of the 8-byte magic and version header
  function automatic logic [7:0] header_byte(input logic [2:0] pos);
    logic [7:0] b;
    unique case (pos)
      3'd1:    b = MAGIC_A;
      3'd2:    b = MAGIC_S;
      3'd3:    b = MAGIC_M;
      3'd4:    b = VERSION_1;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* rtl/wsd_result_fifo.sv */
// ----------------------------------------------------------------------------
// wsd_result_fifo
// small result queue, takes up to two results a cycle, gives one unless the output stalls
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wsd_result_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  wsd_pkg::push_t push_i,
  output logic           room_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output wsd_pkg::res_t  out_res_o
);
  import wsd_pkg::*;

  localparam int unsigned PtrW = $clog2(RQ_DEPTH);
  localparam int unsigned CntW = $clog2(RQ_DEPTH + 1);

  res_t            mem_q [RQ_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            pop;
  logic [PtrW-1:0] wr_ptr_p1;

  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = (count_q != '0);
  assign out_res_o   = mem_q[rd_ptr_q];
  // room for a full pair of results
  assign room_o      = (count_q <= CntW'(RQ_DEPTH - 2));
  assign wr_ptr_p1   = wr_ptr_q + PtrW'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push_i.n);
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
    count_d  = count_q + CntW'(push_i.n) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_ptr_p1] <= push_i.r1;
    end
  end

  `WSD_ASSERT(a_no_overflow, count_q <= CntW'(RQ_DEPTH), "result queue overflow")
  `WSD_ASSERT(a_push_has_room, (push_i.n == 2'd0) || room_o, "push without room for a pair")
  `WSD_ASSERT(a_push_n_legal, push_i.n != 2'd3, "more than two results in one cycle")
  `WSD_ASSERT_NEXT(a_empty_stays, (count_q == '0) && (push_i.n == 2'd0), !out_valid_o,
                   "empty queue shows a result")

endmodule

/* rtl/wasm_section_deframer_core.sv */
// ----------------------------------------------------------------------------
// wasm_section_deframer_core
// checks a webassembly module header and splits the body into sections
// ----------------------------------------------------------------------------
// results pass through the registered result queue and leave in the order of their requests
// rate: one byte per cycle while the queue has room for two results; a final
//   byte that also ends a record or carries a payload byte gives two results
// rate is set by the single-read result queue behind the parser registers
// reset: asynchronous, clears parser state and empties the result queue

module wasm_section_deframer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte requests
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        final_byte_i,
  // result requests
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  section_id_o,
  output logic [31:0] section_size_o,
  output logic [7:0]  payload_byte_o,
  output logic        last_of_run_o
);
  import wsd_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_ID      = 2'd1,
    PH_SIZE    = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_e;

  // parser state
  phase_e      phase_q, phase_d;
  logic [2:0]  hpos_q, hpos_d;
  logic [31:0] acc_q, acc_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [31:0] left_q, left_d;
  logic [7:0]  id_q, id_d;
  logic        fail_q, fail_d;

  logic        in_acc;
  logic        room;
  logic        has_main;
  res_t        main_res;
  res_t        verdict_res;
  logic [31:0] size_part;
  logic [6:0]  leb_bits;
  logic [7:0]  cur_id;
  push_t       push;
  res_t        out_res;

  // take a byte only when the queue can hold two results
  assign in_stall_o = !room;
  assign in_acc     = in_valid_i && room;
  assign leb_bits   = data_byte_i[6:0] & LEB_DATA_MASK[6:0];

  // seven payload bits of the leb128 byte at its place, fifth byte keeps four
  always_comb begin
    unique case (cnt_q)
      3'd0:    size_part = {25'd0, leb_bits};
      3'd1:    size_part = {18'd0, leb_bits, 7'd0};
      3'd2:    size_part = {11'd0, leb_bits, 14'd0};
      3'd3:    size_part = {4'd0, leb_bits, 21'd0};
      3'd4:    size_part = {leb_bits[3:0], 28'd0};
      default: size_part = '0;
    endcase
  end

  always_comb begin
    phase_d  = phase_q;
    hpos_d   = hpos_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    left_d   = left_q;
    id_d     = id_q;
    fail_d   = fail_q;
    has_main = 1'b0;
    main_res = '0;

    if (!fail_q) begin
      unique case (phase_q)
        PH_HEADER: begin
          if (data_byte_i != header_byte(hpos_q)) begin
            fail_d = 1'b1;
          end else if (hpos_q == HDR_LAST) begin
            hpos_d  = '0;
            phase_d = PH_ID;
          end else begin
            hpos_d = hpos_q + 3'd1;
          end
        end
        PH_ID: begin
          id_d    = data_byte_i;
          acc_d   = '0;
          cnt_d   = '0;
          phase_d = PH_SIZE;
        end
        PH_SIZE: begin
          acc_d = acc_q | size_part;
          cnt_d = cnt_q + 3'd1;
          // size ends on a clear continuation bit or after its fifth byte
          if (((data_byte_i & LEB_CONT_MASK) == 8'h00) || (cnt_d >= SIZE_MAX_BYTES)) begin
            has_main              = 1'b1;
            main_res.kind         = KIND_RECORD;
            main_res.section_size = acc_d;
            left_d                = acc_d;
            phase_d               = (acc_d != '0) ? PH_PAYLOAD : PH_ID;
          end
        end
        PH_PAYLOAD: begin
          has_main              = 1'b1;
          main_res.kind         = KIND_PAYLOAD;
          main_res.payload_byte = data_byte_i;
          if (left_q != '0) begin
            left_d = left_q - 32'd1;
          end
          if (left_d == '0) begin
            phase_d = PH_ID;
          end
        end
      endcase
    end

    cur_id              = id_d;
    main_res.section_id = cur_id;

    // verdict on the final byte, then back to the reset state
    verdict_res            = '0;
    verdict_res.section_id = cur_id;
    verdict_res.kind       = (!fail_d && (phase_d == PH_ID)) ? KIND_OK : KIND_FAIL;
    verdict_res.last_of_run = 1'b1;

    if (final_byte_i) begin
      phase_d = PH_HEADER;
      hpos_d  = '0;
      acc_d   = '0;
      cnt_d   = '0;
      left_d  = '0;
      id_d    = '0;
      fail_d  = 1'b0;
    end

    main_res.last_of_run = !final_byte_i;

    push = '0;
    if (in_acc) begin
      if (has_main) begin
        push.r0 = main_res;
        push.r1 = verdict_res;
        push.n  = final_byte_i ? 2'd2 : 2'd1;
      end else if (final_byte_i) begin
        push.r0 = verdict_res;
        push.n  = 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      hpos_q  <= '0;
      acc_q   <= '0;
      cnt_q   <= '0;
      left_q  <= '0;
      id_q    <= '0;
      fail_q  <= 1'b0;
    end else if (in_acc) begin
      phase_q <= phase_d;
      hpos_q  <= hpos_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      left_q  <= left_d;
      id_q    <= id_d;
      fail_q  <= fail_d;
    end
  end

  // result queue decouples the parser from output stalls
  wsd_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res)
  );

  assign kind_o         = out_res.kind;
  assign section_id_o   = out_res.section_id;
  assign section_size_o = out_res.section_size;
  assign payload_byte_o = out_res.payload_byte;
  assign last_of_run_o  = out_res.last_of_run;

endmodule

/* sim/wsd_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wsd_checker
// watches both request channels of the section deframer, predicts the
// results of every accepted byte and compares them in order
// ----------------------------------------------------------------------------
module wsd_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  data_byte_i,
  input  logic        final_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  section_id_i,
  input  logic [31:0] section_size_i,
  input  logic [7:0]  payload_byte_i,
  input  logic        last_of_run_i,
  output int unsigned n_pending_o,
  output int unsigned n_errors_o
);
  import wsd_pkg::*;

  typedef enum logic [1:0] {
    ST_HEADER,
    ST_ID,
    ST_SIZE,
    ST_PAYLOAD
  } parse_phase_e;

  // module preamble, first byte in the low lane
  localparam logic [63:0] WASM_PREAMBLE = 64'h0000_0001_6D73_6100;
  localparam int unsigned LEB_MAX_BYTES = 5;
  localparam int unsigned REPORT_MAX    = 10;

  parse_phase_e phase;
  logic [2:0]   hdr_pos;
  logic [31:0]  size_acc;
  logic [2:0]   size_cnt;
  logic [31:0]  remaining;
  logic [7:0]   cur_id;
  logic         failed;

  res_t expected_q[$];

  initial begin
    n_pending_o = 0;
    n_errors_o  = 0;
  end

  task automatic clear_parser();
    phase     = ST_HEADER;
    hdr_pos   = '0;
    size_acc  = '0;
    size_cnt  = '0;
    remaining = '0;
    cur_id    = '0;
    failed    = 1'b0;
  endtask

  function automatic res_t section_result(input kind_e k, input logic [31:0] sz,
                                          input logic [7:0] pb);
    res_t r;
    r.kind         = k;
    r.section_id   = cur_id;
    r.section_size = sz;
    r.payload_byte = pb;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

  // add one predicted result at the tail
  task automatic queue_result(input res_t r);
    expected_q.insert(expected_q.size(), r);
  endtask

  // advance the parser by one byte and queue what it emits
  task automatic deframe_byte(input logic [7:0] b, input logic fin);
    int   n;
    logic ok;
    res_t tail;
    n = 0;
    if (!failed) begin
      case (phase)
        ST_HEADER: begin
          if (b != WASM_PREAMBLE[8*hdr_pos +: 8]) begin
            failed = 1'b1;
          end else if (hdr_pos == 3'd7) begin
            hdr_pos = '0;
            phase   = ST_ID;
          end else begin
            hdr_pos = hdr_pos + 3'd1;
          end
        end
        ST_ID: begin
          cur_id   = b;
          size_acc = '0;
          size_cnt = '0;
          phase    = ST_SIZE;
        end
        ST_SIZE: begin
          // bits above 32 fall off the shift
          size_acc = size_acc | (32'(b[6:0]) << (7 * size_cnt));
          size_cnt = size_cnt + 3'd1;
          if (!b[7] || size_cnt == LEB_MAX_BYTES) begin
            queue_result(section_result(KIND_RECORD, size_acc, 8'h00));
            n++;
            remaining = size_acc;
            phase     = (remaining != 0) ? ST_PAYLOAD : ST_ID;
          end
        end
        default: begin
          queue_result(section_result(KIND_PAYLOAD, 32'h0, b));
          n++;
          if (remaining != 0) remaining = remaining - 32'd1;
          if (remaining == 0) phase = ST_ID;
        end
      endcase
    end
    if (fin) begin
      ok = !failed && phase == ST_ID;
      queue_result(section_result(ok ? KIND_OK : KIND_FAIL, 32'h0, 8'h00));
      n++;
      clear_parser();
    end
    if (n > 0) begin
      tail = expected_q[expected_q.size() - 1];
      tail.last_of_run = 1'b1;
      expected_q[expected_q.size() - 1] = tail;
    end
  endtask

  task automatic check_result();
    res_t got;
    res_t want;
    got.kind         = kind_e'(kind_i);
    got.section_id   = section_id_i;
    got.section_size = section_size_i;
    got.payload_byte = payload_byte_i;
    got.last_of_run  = last_of_run_i;
    if (expected_q.size() == 0) begin
      if (n_errors_o < REPORT_MAX)
        $display("unexpected result: kind %0d id %h size %h byte %h last %0d",
                 got.kind, got.section_id, got.section_size, got.payload_byte,
                 got.last_of_run);
      n_errors_o++;
    end else begin
      want = expected_q.pop_front();
      if (got.kind != want.kind || got.section_id != want.section_id ||
          got.section_size != want.section_size ||
          got.payload_byte != want.payload_byte ||
          got.last_of_run != want.last_of_run) begin
        if (n_errors_o < REPORT_MAX)
          $display("mismatch (exp/act): kind %0d/%0d id %h/%h size %h/%h byte %h/%h last %0d/%0d",
                   want.kind, got.kind, want.section_id, got.section_id,
                   want.section_size, got.section_size, want.payload_byte,
                   got.payload_byte, want.last_of_run, got.last_of_run);
        n_errors_o++;
      end
    end
  endtask

  // results leave through a registered queue, never in the cycle of their request, so check before predicting
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      clear_parser();
      expected_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) check_result();
      if (in_valid_i && !in_stall_i) deframe_byte(data_byte_i, final_byte_i);
    end
    n_pending_o = expected_q.size();
  end

endmodule

/* sim/tb_wasm_section_deframer_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_wasm_section_deframer_core
// feeds whole and broken module binaries byte by byte into the deframer,
// with random gaps and output stalls; a checker beside the block predicts
// every record, payload byte and verdict and counts the mismatches
// ----------------------------------------------------------------------------
module tb_wasm_section_deframer_core;
  import wsd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned TARGET_ITEMS = 400;
  // idling stops once the rough byte count items_sent reaches this
  localparam int unsigned CALM_ITEMS   = 340;
  localparam int unsigned DRAIN_CYCLES = 8;

  // preamble with the first byte in the low lane
  localparam logic [63:0] HDR_BYTES =
    {8'h00, 8'h00, 8'h00, VERSION_1, MAGIC_M, MAGIC_S, MAGIC_A, 8'h00};

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        final_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  kind_o;
  logic [7:0]  section_id_o;
  logic [31:0] section_size_o;
  logic [7:0]  payload_byte_o;
  logic        last_of_run_o;

  int unsigned n_pending;
  int unsigned n_errors;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;   // bytes the parser acts on, roughly
  logic        quiet_tail = 1'b0;
  logic        tx_calm = 1'b0;

  // bytes of the module being sent, the last one carries the final flag
  logic [7:0]  mod_q[$];

  wasm_section_deframer_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .final_byte_i   (final_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .section_id_o   (section_id_o),
    .section_size_o (section_size_o),
    .payload_byte_o (payload_byte_o),
    .last_of_run_o  (last_of_run_o)
  );

  wsd_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .final_byte_i   (final_byte_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_i         (kind_o),
    .section_id_i   (section_id_o),
    .section_size_i (section_size_o),
    .payload_byte_i (payload_byte_o),
    .last_of_run_i  (last_of_run_o),
    .n_pending_o    (n_pending),
    .n_errors_o     (n_errors)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // watchdog: a hung handshake or a lost result ends up here
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  // result side stalls in bursts, with calm stretches in between
  initial begin
    int unsigned burst;
    int unsigned span;
    logic        rx_calm;
    burst       = 0;
    span        = 0;
    rx_calm     = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (span == 0) begin
        span    = $urandom_range(50, 300);
        rx_calm = ($urandom_range(0, 3) == 0);
      end else begin
        span--;
      end
      if (burst > 0) begin
        out_stall_i <= 1'b1;
        burst--;
      end else begin
        out_stall_i <= 1'b0;
        if (!quiet_tail && !rx_calm && $urandom_range(0, 5) == 0)
          burst = $urandom_range(1, 13);
      end
    end
  end

  // add one byte at the end of the module being built
  task automatic append_byte(input logic [7:0] b);
    mod_q.insert(mod_q.size(), b);
  endtask

  task automatic put_header();
    for (int i = 0; i < 8; i++) append_byte(HDR_BYTES[8*i +: 8]);
  endtask

  // unsigned leb128 with optional padding bytes; a fifth byte gets junk in
  // its top bits, which the block must drop
  task automatic put_leb(input logic [31:0] value, input int unsigned pad);
    int unsigned n;
    logic [7:0]  b;
    n = 1;
    while (n < 5 && (value >> (7 * n)) != 0) n++;
    n = (n + pad > 5) ? 5 : n + pad;
    for (int i = 0; i < n; i++) begin
      b = {1'b0, 7'(value >> (7 * i))};
      if (i < n - 1) b[7] = 1'b1;
      if (i == 4) b[7:4] = 4'($urandom);
      append_byte(b);
    end
  endtask

  // one request: optional gap, then hold the byte until it is taken
  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (!quiet_tail && !tx_calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    data_byte_i  <= b;
    final_byte_i <= fin;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic send_module();
    for (int i = 0; i < mod_q.size(); i++) send_byte(mod_q[i], i == mod_q.size() - 1);
    mod_q.delete();
    if (items_sent >= CALM_ITEMS) quiet_tail = 1'b1;
  endtask

  // sender holds off until every predicted result has come out
  task automatic drain_results();
    in_valid_i <= 1'b0;
    wait (n_pending == 0);
    @(negedge clk_i);
  endtask

  task automatic build_random_module();
    int unsigned pick;
    int unsigned nsec;
    int unsigned cut;
    logic [31:0] size;
    pick = $urandom_range(0, 99);
    if (pick < 72) begin
      // well-formed module, sometimes cut short at a random byte
      put_header();
      nsec = $urandom_range(0, 4);
      for (int s = 0; s < nsec; s++) begin
        append_byte(8'($urandom));
        if ($urandom_range(0, 6) == 0) begin
          // size far beyond what is sent, so the payload is truncated
          size = $urandom;
          put_leb(size, 0);
          repeat ($urandom_range(0, 3)) append_byte(8'($urandom));
          break;
        end
        size = ($urandom_range(0, 9) == 0) ? $urandom_range(120, 140)
                                            : $urandom_range(0, 8);
        put_leb(size, $urandom_range(0, 2));
        repeat (size) append_byte(8'($urandom));
      end
      if ($urandom_range(0, 3) == 0) begin
        cut = $urandom_range(1, mod_q.size());
        while (mod_q.size() > cut) mod_q.delete(mod_q.size() - 1);
      end
      items_sent += mod_q.size();
    end else if (pick < 86) begin
      // header mismatch at a random position, then ignored trailing bytes
      cut = $urandom_range(0, 7);
      for (int i = 0; i < cut; i++) append_byte(HDR_BYTES[8*i +: 8]);
      append_byte(HDR_BYTES[8*cut +: 8] ^ 8'($urandom_range(1, 255)));
      repeat ($urandom_range(0, 10)) append_byte(8'($urandom));
      items_sent += cut + 2;
    end else begin
      // plain noise
      repeat ($urandom_range(1, 12)) append_byte(8'($urandom));
      items_sent += 2;
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    data_byte_i  = 8'h00;
    final_byte_i = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // header only: ok on the eighth byte
    put_header();
    send_module();

    // lone final byte: fail straight from the header
    append_byte(8'h00);
    send_module();

    // header mismatch, then bytes that must be ignored up to the final one
    append_byte(8'h00);
    append_byte(MAGIC_A);
    append_byte(8'hFF);
    append_byte(8'h55);
    append_byte(8'hAA);
    send_module();

    // zero-size section, then a five-byte all-ones size that truncates
    put_header();
    append_byte(8'h00);
    append_byte(8'h00);
    append_byte(8'hFF);
    repeat (5) append_byte(8'hFF);
    send_module();
    items_sent = 22;
    drain_results();

    while (items_sent < TARGET_ITEMS) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      build_random_module();
      send_module();
      if ($urandom_range(0, 5) == 0) drain_results();
    end

    in_valid_i <= 1'b0;
    wait (n_pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/wsd_pkg.sv
rtl/wsd_result_fifo.sv
rtl/wasm_section_deframer_core.sv
sim/wsd_checker.sv
sim/tb_wasm_section_deframer_core.sv
